// ----- hw/rtl/rie_pkg.sv -----
`default_nettype none
package rie_pkg;

  localparam int MEM_WORDS_DEF = 4096;
  localparam int IO_COUNT_DEF  = 32;
  localparam int PC_W          = 12;
  localparam int XLEN          = 32;
  localparam int RIDX_W        = 4;
  localparam int IOIDX_W       = 5;

  localparam logic [RIDX_W-1:0] LINK_REG = 4'd15;

  // Branch condition codes carried in the src_c register field.
  localparam logic [3:0] CC_EQ = 4'd0;
  localparam logic [3:0] CC_NE = 4'd1;
  localparam logic [3:0] CC_GT = 4'd2;
  localparam logic [3:0] CC_LT = 4'd3;
  localparam logic [3:0] CC_GE = 4'd4;
  localparam logic [3:0] CC_LE = 4'd5;

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_AND    = 4'd2,
    OP_OR     = 4'd3,
    OP_SLL    = 4'd4,
    OP_SRA    = 4'd5,
    OP_MAC    = 4'd6,
    OP_BRANCH = 4'd7,
    OP_IN     = 4'd8,
    OP_OUT    = 4'd9,
    OP_NOP    = 4'd10,
    OP_JAL    = 4'd11,
    OP_LW     = 4'd12,
    OP_SW     = 4'd13,
    OP_JR     = 4'd14,
    OP_HALT   = 4'd15
  } op_t;

  typedef enum logic [2:0] {
    CLS_ALU,
    CLS_MAC,
    CLS_LOAD,
    CLS_STORE,
    CLS_CTRL
  } cls_t;

  typedef struct packed {
    op_t               op;
    logic [RIDX_W-1:0] dest;
    logic [RIDX_W-1:0] src_a;
    logic [RIDX_W-1:0] src_b;
    logic [RIDX_W-1:0] src_c;
    logic [PC_W-1:0]   imm;
    cls_t              cls;
    logic              port1_rd;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef struct packed {
    logic [PC_W-1:0]    next_pc;
    logic               halted;
    logic               wb_valid;
    logic [RIDX_W-1:0]  wb_reg;
    logic [XLEN-1:0]    wb_data;
    logic               io_valid;
    logic [IOIDX_W-1:0] io_index;
    logic [XLEN-1:0]    io_data;
  } result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_FETCH,
    ST_EXEC,
    ST_MAC,
    ST_ADDR,
    ST_LOAD
  } bstate_t;

  function automatic logic [XLEN-1:0] sx12(input logic [PC_W-1:0] v);
    return {{(XLEN-PC_W){v[PC_W-1]}}, v};
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/rie_if.sv -----
`default_nettype none
interface rie_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  cmd;
  logic [3:0]  dest_reg;
  logic [3:0]  src_a_reg;
  logic [3:0]  src_b_reg;
  logic [3:0]  src_c_reg;
  logic [11:0] immediate;

  modport source (output valid, cmd, dest_reg, src_a_reg, src_b_reg, src_c_reg, immediate,
                  input ready);
  modport sink (input valid, cmd, dest_reg, src_a_reg, src_b_reg, src_c_reg, immediate,
                output ready);
endinterface

interface rie_out_if;
  logic               valid;
  logic               ready;
  logic [11:0]        next_pc;
  logic               halted;
  logic               wb_valid;
  logic [3:0]         wb_reg;
  logic signed [31:0] wb_data;
  logic               io_write_valid;
  logic [4:0]         io_index;
  logic signed [31:0] io_data;

  modport source (output valid, next_pc, halted, wb_valid, wb_reg, wb_data, io_write_valid,
                  io_index, io_data, input ready);
  modport sink (input valid, next_pc, halted, wb_valid, wb_reg, wb_data, io_write_valid,
                io_index, io_data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/rie_front.sv -----
`default_nettype none
module rie_front (
  input  logic            clk,
  input  logic            rst_n,
  rie_in_if.sink          in_ch,
  input  logic            run,
  input  logic            pop,
  output rie_pkg::q_head_t head
);
  import rie_pkg::*;

  item_t      entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  item_t      dec;
  logic       push;

  // Classify the incoming instruction by the resources it needs.
  always_comb begin
    dec.op       = op_t'(in_ch.cmd);
    dec.dest     = in_ch.dest_reg;
    dec.src_a    = in_ch.src_a_reg;
    dec.src_b    = in_ch.src_b_reg;
    dec.src_c    = in_ch.src_c_reg;
    dec.imm      = in_ch.immediate;
    dec.port1_rd = (dec.op inside {OP_OUT, OP_SW, OP_JR});
    if (dec.op inside {OP_ADD, OP_SUB, OP_AND, OP_OR, OP_SLL, OP_SRA}) begin
      dec.cls = CLS_ALU;
    end else if (dec.op == OP_MAC) begin
      dec.cls = CLS_MAC;
    end else if (dec.op inside {OP_LW, OP_IN}) begin
      dec.cls = CLS_LOAD;
    end else if (dec.op inside {OP_SW, OP_OUT}) begin
      dec.cls = CLS_STORE;
    end else begin
      dec.cls = CLS_CTRL;
    end
  end

  assign in_ch.ready = run && (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;

  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= dec;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/rie_mod.sv -----
`default_nettype none
module rie_mod #(
  parameter int DIV = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [31:0]             dividend,
  output logic                    done,
  output logic [$clog2(DIV)-1:0]  rem
);
  localparam int          RW      = $clog2(DIV);
  localparam bit          POW2    = ((DIV & (DIV - 1)) == 0);
  localparam int          SH      = 32 + RW;
  localparam logic [63:0] DIV64   = 64'(DIV);
  localparam logic [63:0] RECIP64 = ((64'd1 << SH) + DIV64 - 64'd1) / DIV64;
  localparam logic [32:0] RECIP   = RECIP64[32:0];
  localparam logic [RW-1:0] DIVL  = RW'(DIV);

  logic [RW-1:0] rem_r, rem_nxt;
  logic [RW-1:0] x_r, x_nxt;
  logic [RW-1:0] q_r, q_nxt;
  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [64:0]   prod;

  // The quotient comes from a multiply by the rounded-up reciprocal, which is
  // exact for every 32-bit dividend; only its low bits matter for the remainder.
  assign prod = 65'(dividend) * 65'(RECIP);

  always_comb begin
    rem_nxt  = rem_r;
    x_nxt    = x_r;
    q_nxt    = q_r;
    run_nxt  = run_r;
    done_nxt = done_r;
    if (start) begin
      if (POW2) begin
        rem_nxt  = dividend[RW-1:0];
        done_nxt = 1'b1;
        run_nxt  = 1'b0;
      end else begin
        x_nxt    = dividend[RW-1:0];
        q_nxt    = prod[SH +: RW];
        run_nxt  = 1'b1;
        done_nxt = 1'b0;
      end
    end else if (run_r) begin
      rem_nxt  = x_r - q_r * DIVL;
      run_nxt  = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    x_r   <= x_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

// ----- hw/rtl/rie_back.sv -----
`default_nettype none
module rie_back #(
  parameter int MEM_WORDS = rie_pkg::MEM_WORDS_DEF,
  parameter int IO_COUNT  = rie_pkg::IO_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rie_pkg::q_head_t head,
  output logic             pop,
  output logic             run,
  rie_out_if.source        out_ch
);
  import rie_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);
  localparam int IW = $clog2(IO_COUNT);

  logic [XLEN-1:0] rf      [16];
  logic [XLEN-1:0] dmem    [MEM_WORDS];
  logic [XLEN-1:0] io_mem  [IO_COUNT];

  bstate_t         state_r, state_nxt;
  logic [AW-1:0]   cnt_r, cnt_nxt;
  logic [PC_W-1:0] pc_r;
  logic            halt_r;
  logic            out_valid_r;
  result_t         out_res_r;
  item_t           item_r;
  logic [XLEN-1:0] prod_r;
  logic [XLEN-1:0] rf_q0, rf_q1, dmem_q, io_q;

  logic [RIDX_W-1:0] addr0, addr1;
  logic [AW-1:0]     mem_rem;
  logic [IW-1:0]     io_rem;
  logic              mem_done, io_done, mod_done, mod_start;
  logic              out_free, commit, clearing, clr_last, is_mem;
  logic [XLEN-1:0]   se, a, b, addr_sum;
  logic [PC_W-1:0]   pc_inc;
  logic [4:0]        sh;
  logic              take;
  result_t           res;

  assign out_free = !out_valid_r || out_ch.ready;
  assign clr_last = (cnt_r == AW'(MEM_WORDS - 1));
  assign is_mem   = (item_r.cls == CLS_LOAD) || (item_r.cls == CLS_STORE);
  assign a        = rf_q0;
  assign b        = rf_q1;
  assign se       = sx12(item_r.imm);
  assign addr_sum = a + se;
  assign pc_inc   = pc_r + 12'd1;
  assign sh       = b[4:0] + item_r.imm[4:0];
  assign mod_done = mem_done && io_done;

  rie_mod #(.DIV(MEM_WORDS)) u_mem_mod (
    .clk(clk), .rst_n(rst_n), .start(mod_start), .dividend(addr_sum),
    .done(mem_done), .rem(mem_rem)
  );

  rie_mod #(.DIV(IO_COUNT)) u_io_mod (
    .clk(clk), .rst_n(rst_n), .start(mod_start), .dividend(addr_sum),
    .done(io_done), .rem(io_rem)
  );

  // Register file read addresses; a multiply-accumulate rereads port 0 for rm.
  always_comb begin
    if (state_r == ST_FETCH) begin
      addr0 = head.item.src_a;
      addr1 = head.item.port1_rd ? head.item.dest : head.item.src_b;
    end else begin
      addr0 = item_r.src_a;
      addr1 = item_r.port1_rd ? item_r.dest : item_r.src_b;
      if ((state_r == ST_EXEC || state_r == ST_MAC) && item_r.cls == CLS_MAC) begin
        addr0 = item_r.src_c;
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_last) state_nxt = ST_FETCH;
      ST_FETCH: if (head.valid) state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (!halt_r && item_r.cls == CLS_MAC) begin
          state_nxt = ST_MAC;
        end else if (!halt_r && is_mem) begin
          state_nxt = ST_ADDR;
        end else if (out_free) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_MAC:  if (out_free) state_nxt = ST_FETCH;
      ST_ADDR: begin
        if (mod_done) begin
          if (item_r.cls == CLS_LOAD) begin
            state_nxt = ST_LOAD;
          end else if (out_free) begin
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_LOAD: if (out_free) state_nxt = ST_FETCH;
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Control outputs.
  always_comb begin
    pop       = 1'b0;
    mod_start = 1'b0;
    commit    = 1'b0;
    clearing  = 1'b0;
    case (state_r)
      ST_CLEAR: clearing = 1'b1;
      ST_FETCH: pop = head.valid;
      ST_EXEC: begin
        mod_start = !halt_r && is_mem;
        commit    = out_free && (halt_r || !(is_mem || item_r.cls == CLS_MAC));
      end
      ST_MAC:  commit = out_free;
      ST_ADDR: commit = out_free && mod_done && (item_r.cls == CLS_STORE);
      ST_LOAD: commit = out_free;
      default: clearing = 1'b0;
    endcase
  end

  assign run = !clearing;

  // Result of the instruction in flight.
  always_comb begin
    res         = '0;
    res.next_pc = pc_inc;
    res.halted  = halt_r;
    take        = 1'b0;
    if (halt_r) begin
      res.next_pc = pc_r;
    end else begin
      case (item_r.op)
        OP_ADD: begin res.wb_valid = 1'b1; res.wb_data = a + b + se; end
        OP_SUB: begin res.wb_valid = 1'b1; res.wb_data = a - b - se; end
        OP_AND: begin res.wb_valid = 1'b1; res.wb_data = a & b & se; end
        OP_OR:  begin res.wb_valid = 1'b1; res.wb_data = a | b | se; end
        OP_SLL: begin res.wb_valid = 1'b1; res.wb_data = a << sh; end
        OP_SRA: begin res.wb_valid = 1'b1; res.wb_data = XLEN'($signed(a) >>> sh); end
        OP_MAC: begin res.wb_valid = 1'b1; res.wb_data = prod_r + a + se; end
        OP_BRANCH: begin
          case (item_r.src_c)
            CC_EQ:   take = (a == b);
            CC_NE:   take = (a != b);
            CC_GT:   take = ($signed(a) > $signed(b));
            CC_LT:   take = ($signed(a) < $signed(b));
            CC_GE:   take = ($signed(a) >= $signed(b));
            CC_LE:   take = ($signed(a) <= $signed(b));
            default: take = 1'b0;
          endcase
          if (take) res.next_pc = item_r.imm;
        end
        OP_IN: begin res.wb_valid = 1'b1; res.wb_data = io_q; end
        OP_OUT: begin
          res.io_valid = 1'b1;
          res.io_index = IOIDX_W'(io_rem);
          res.io_data  = b;
        end
        OP_JAL: begin
          res.wb_valid = 1'b1;
          res.wb_data  = XLEN'(pc_inc);
          res.next_pc  = item_r.imm;
        end
        OP_LW:   begin res.wb_valid = 1'b1; res.wb_data = dmem_q; end
        OP_SW:   res.next_pc = pc_inc;
        OP_JR:   res.next_pc = b[PC_W-1:0];
        OP_HALT: begin res.halted = 1'b1; res.next_pc = pc_r; end
        default: res.next_pc = pc_r;
      endcase
      if (res.wb_valid) begin
        res.wb_reg = (item_r.op == OP_JAL) ? LINK_REG : item_r.dest;
      end
    end
  end

  always_comb begin
    cnt_nxt = clearing ? cnt_r + AW'(1) : cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      pc_r        <= '0;
      halt_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (commit) begin
        pc_r        <= res.next_pc;
        halt_r      <= res.halted;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) item_r <= head.item;
    if (state_r == ST_EXEC) prod_r <= a * b;
    if (commit) out_res_r <= res;
  end

  // Register file: two read ports, one write port shared with the clearing pass.
  always_ff @(posedge clk) begin
    rf_q0 <= rf[addr0];
    rf_q1 <= rf[addr1];
    if (clearing) begin
      rf[cnt_r[RIDX_W-1:0]] <= '0;
    end else if (commit && res.wb_valid) begin
      rf[res.wb_reg] <= res.wb_data;
    end
  end

  always_ff @(posedge clk) begin
    dmem_q <= dmem[mem_rem];
    if (clearing) begin
      dmem[cnt_r] <= '0;
    end else if (commit && !halt_r && item_r.op == OP_SW) begin
      dmem[mem_rem] <= b;
    end
  end

  always_ff @(posedge clk) begin
    io_q <= io_mem[io_rem];
    if (clearing) begin
      if (32'(cnt_r) < 32'(IO_COUNT)) begin
        io_mem[cnt_r[IW-1:0]] <= '0;
      end
    end else if (commit && res.io_valid) begin
      io_mem[io_rem] <= b;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.next_pc        = out_res_r.next_pc;
  assign out_ch.halted         = out_res_r.halted;
  assign out_ch.wb_valid       = out_res_r.wb_valid;
  assign out_ch.wb_reg         = out_res_r.wb_reg;
  assign out_ch.wb_data        = out_res_r.wb_data;
  assign out_ch.io_write_valid = out_res_r.io_valid;
  assign out_ch.io_index       = out_res_r.io_index;
  assign out_ch.io_data        = out_res_r.io_data;

endmodule
`default_nettype wire

// ----- hw/rtl/risc_instruction_execute.sv -----
// Instruction execute block for a small 32-bit RISC machine.
// in_ch carries one decoded instruction per transaction (valid/ready);
// out_ch returns one result per instruction in order: next pc, halt
// status, register writeback and I/O write.
// After rst_n is released the block first runs a clearing pass over the
// data memory, I/O store and register file, stepping through all
// MEM_WORDS addresses; in_ch.ready stays low during it.
// Instructions enter a two-entry queue, so the front keeps taking
// transactions while the back end works or waits on out_ch.
// The back end reads the register file in ST_FETCH and executes in
// ST_EXEC, which covers ALU, branch, jump and halt; multiply-
// accumulate adds ST_MAC (second register read for rm). Memory and I/O
// accesses add ST_ADDR for the address remainder units (a registered
// reciprocal multiply unless a power of two), plus ST_LOAD for loads.
// Results sit in an output register; while out_ch.ready is low the back
// end holds and the queue fills, then in_ch.ready drops.
`default_nettype none
module risc_instruction_execute #(
  parameter int MEM_WORDS = rie_pkg::MEM_WORDS_DEF,
  parameter int IO_COUNT  = rie_pkg::IO_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rie_in_if.sink    in_ch,
  rie_out_if.source out_ch
);
  import rie_pkg::*;

  q_head_t head;
  logic    pop;
  logic    run;

  rie_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .run(run), .pop(pop), .head(head)
  );

  rie_back #(.MEM_WORDS(MEM_WORDS), .IO_COUNT(IO_COUNT)) u_back (
    .clk(clk), .rst_n(rst_n), .head(head), .pop(pop), .run(run), .out_ch(out_ch)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/rie_checker.sv -----
`default_nettype none
module rie_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_halted,
  input logic        out_wb_valid,
  input logic [3:0]  out_wb_reg,
  input logic [31:0] out_wb_data,
  input logic        out_io_valid,
  input logic [4:0]  out_io_index,
  input logic [31:0] out_io_data
);

  // A pending result is not withdrawn while the receiver stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // The clearing pass keeps the input closed right after reset.
  a_clear_closed: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input open during clearing pass");

  // A halted machine reports no writes.
  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_halted |-> !out_wb_valid && !out_io_valid)
    else $error("write reported after halt");

  a_wb_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_wb_valid |-> out_wb_reg == 4'd0 && out_wb_data == 32'd0)
    else $error("writeback fields not zero");

  a_io_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_io_valid |-> out_io_index == 5'd0 && out_io_data == 32'd0)
    else $error("I/O fields not zero");

endmodule

bind risc_instruction_execute rie_checker u_rie_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_halted(out_ch.halted),
  .out_wb_valid(out_ch.wb_valid),
  .out_wb_reg(out_ch.wb_reg),
  .out_wb_data(out_ch.wb_data),
  .out_io_valid(out_ch.io_write_valid),
  .out_io_index(out_ch.io_index),
  .out_io_data(out_ch.io_data)
);
`default_nettype wire

// ----- tb/tb_risc_instruction_execute.sv -----
module tb_risc_instruction_execute;
  import rie_pkg::*;

  logic clk;
  logic rst_n;
  rie_in_if in_ch ();
  rie_out_if out_ch ();

  risc_instruction_execute dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Machine state as the predictor sees it.
  logic [31:0] regs_m [16];
  logic [31:0] dmem_m [MEM_WORDS_DEF];
  logic [31:0] io_m [IO_COUNT_DEF];
  logic [11:0] pc_m;
  logic        halt_m;

  result_t expected_results[$];
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_off_cycles;
  bit   failed;

  function automatic result_t execute_instr(op_t op, logic [3:0] rd, logic [3:0] rs,
                                            logic [3:0] rt, logic [3:0] rm,
                                            logic [11:0] imm);
    result_t r;
    logic [31:0] a, b, se;
    logic [11:0] pc_inc, nxt;
    logic take;
    a = regs_m[rs];
    b = regs_m[rt];
    se = {{20{imm[11]}}, imm};
    pc_inc = pc_m + 12'd1;
    nxt = pc_inc;
    r = '0;
    take = 1'b0;
    if (halt_m) begin
      r.next_pc = pc_m;
      r.halted = 1'b1;
      return r;
    end
    case (op)
      OP_ADD: begin r.wb_valid = 1; r.wb_reg = rd; r.wb_data = a + b + se; end
      OP_SUB: begin r.wb_valid = 1; r.wb_reg = rd; r.wb_data = a - b - se; end
      OP_AND: begin r.wb_valid = 1; r.wb_reg = rd; r.wb_data = a & b & se; end
      OP_OR: begin r.wb_valid = 1; r.wb_reg = rd; r.wb_data = a | b | se; end
      OP_SLL: begin
        r.wb_valid = 1; r.wb_reg = rd;
        r.wb_data = a << ((b + {20'd0, imm}) & 32'd31);
      end
      OP_SRA: begin
        r.wb_valid = 1; r.wb_reg = rd;
        r.wb_data = $signed(a) >>> ((b + {20'd0, imm}) & 32'd31);
      end
      OP_MAC: begin
        r.wb_valid = 1; r.wb_reg = rd;
        r.wb_data = a * b + regs_m[rm] + se;
      end
      OP_BRANCH: begin
        case (rm)
          CC_EQ: take = $signed(a) == $signed(b);
          CC_NE: take = $signed(a) != $signed(b);
          CC_GT: take = $signed(a) > $signed(b);
          CC_LT: take = $signed(a) < $signed(b);
          CC_GE: take = $signed(a) >= $signed(b);
          CC_LE: take = $signed(a) <= $signed(b);
          default: take = 1'b0;
        endcase
        if (take) nxt = imm;
      end
      OP_IN: begin
        r.wb_valid = 1; r.wb_reg = rd;
        r.wb_data = io_m[5'((a + se) % IO_COUNT_DEF)];
      end
      OP_OUT: begin
        r.io_valid = 1;
        r.io_index = 5'((a + se) % IO_COUNT_DEF);
        r.io_data = regs_m[rd];
        io_m[r.io_index] = r.io_data;
      end
      OP_JAL: begin
        r.wb_valid = 1; r.wb_reg = LINK_REG; r.wb_data = {20'd0, pc_inc};
        nxt = imm;
      end
      OP_LW: begin
        r.wb_valid = 1; r.wb_reg = rd;
        r.wb_data = dmem_m[12'((a + se) % MEM_WORDS_DEF)];
      end
      OP_SW: dmem_m[12'((a + se) % MEM_WORDS_DEF)] = regs_m[rd];
      OP_JR: nxt = regs_m[rd][11:0];
      OP_HALT: begin halt_m = 1'b1; nxt = pc_m; end
      default: nxt = pc_m;
    endcase
    if (r.wb_valid) regs_m[r.wb_reg] = r.wb_data;
    pc_m = nxt;
    r.next_pc = pc_m;
    r.halted = halt_m;
    return r;
  endfunction

  // Valid stays high after a transaction so that items can follow back to back;
  // idle cycles and the drain wait take it low.
  task automatic send_instr(op_t op, logic [3:0] rd, logic [3:0] rs, logic [3:0] rt,
                            logic [3:0] rm, logic [11:0] imm);
    if (send_idle_pct > 0) begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_ch.valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= op;
    in_ch.dest_reg <= rd;
    in_ch.src_a_reg <= rs;
    in_ch.src_b_reg <= rt;
    in_ch.src_c_reg <= rm;
    in_ch.immediate <= imm;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_results.push_back(execute_instr(op, rd, rs, rt, rm, imm));
    @(negedge clk);
  endtask

  // Receiver readiness, updated on the falling edge.
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected transaction pc=%h", $time, out_ch.next_pc);
        failed = 1'b1;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_ch.next_pc !== exp_r.next_pc || out_ch.halted !== exp_r.halted ||
            out_ch.wb_valid !== exp_r.wb_valid || out_ch.wb_reg !== exp_r.wb_reg ||
            out_ch.wb_data !== exp_r.wb_data || out_ch.io_write_valid !== exp_r.io_valid ||
            out_ch.io_index !== exp_r.io_index || out_ch.io_data !== exp_r.io_data) begin
          $display("%0t: mismatch expected pc=%h h=%b wb=%b/%h/%h io=%b/%h/%h", $time,
                   exp_r.next_pc, exp_r.halted, exp_r.wb_valid, exp_r.wb_reg,
                   exp_r.wb_data, exp_r.io_valid, exp_r.io_index, exp_r.io_data);
          $display("%0t:          actual   pc=%h h=%b wb=%b/%h/%h io=%b/%h/%h", $time,
                   out_ch.next_pc, out_ch.halted, out_ch.wb_valid, out_ch.wb_reg,
                   out_ch.wb_data, out_ch.io_write_valid, out_ch.io_index, out_ch.io_data);
          failed = 1'b1;
        end
      end
    end
  end

  function automatic op_t rand_op();
    return op_t'(4'($urandom_range(14)));
  endfunction

  // Registers are mostly loaded through add with a random immediate, so a small
  // pool of addresses keeps loads hitting stored words and I/O round trips.
  task automatic send_random(int count);
    op_t op;
    logic [11:0] imm;
    for (int i = 0; i < count; i++) begin
      op = rand_op();
      imm = 12'($urandom_range(4095));
      if ((op == OP_LW || op == OP_SW || op == OP_IN || op == OP_OUT) && $urandom_range(3) != 0)
        imm = 12'($urandom_range(7));
      if (op == OP_BRANCH && $urandom_range(7) == 0)
        send_instr(op, 4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom_range(15)), imm);
      else if (op == OP_BRANCH)
        send_instr(op, 4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom_range(5)), imm);
      else if (op == OP_MAC && $urandom_range(1))
        send_instr(OP_ADD, 4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom),
                   12'($urandom));
      else
        send_instr(op, 4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom), imm);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed_ops();
    send_instr(OP_ADD, 4'd1, 4'd0, 4'd0, 4'd0, 12'h7ff);
    send_instr(OP_SUB, 4'd2, 4'd0, 4'd1, 4'd0, 12'h800);
    send_instr(OP_ADD, 4'd3, 4'd2, 4'd2, 4'd0, 12'hfff);
    send_instr(OP_AND, 4'd4, 4'd3, 4'd2, 4'd0, 12'hfff);
    send_instr(OP_OR, 4'd5, 4'd1, 4'd0, 4'd0, 12'h800);
    send_instr(OP_SLL, 4'd6, 4'd1, 4'd0, 4'd0, 12'hfff);
    send_instr(OP_SRA, 4'd7, 4'd5, 4'd0, 4'd0, 12'h01f);
    send_instr(OP_SRA, 4'd7, 4'd5, 4'd0, 4'd0, 12'h000);
    send_instr(OP_MAC, 4'd8, 4'd3, 4'd5, 4'd1, 12'hfff);
    for (int cc = 0; cc < 7; cc++)
      send_instr(OP_BRANCH, 4'd0, 4'd1, 4'd2, cc[3:0], 12'hffe);
    send_instr(OP_BRANCH, 4'd0, 4'd1, 4'd1, 4'd15, 12'h123);
    send_instr(OP_OUT, 4'd3, 4'd2, 4'd0, 4'd0, 12'hfff);
    send_instr(OP_IN, 4'd9, 4'd2, 4'd0, 4'd0, 12'hfff);
    send_instr(OP_SW, 4'd5, 4'd3, 4'd0, 4'd0, 12'h800);
    send_instr(OP_LW, 4'd10, 4'd3, 4'd0, 4'd0, 12'h800);
    send_instr(OP_JAL, 4'd0, 4'd0, 4'd0, 4'd0, 12'hfff);
    send_instr(OP_NOP, 4'hf, 4'hf, 4'hf, 4'hf, 12'hfff);
    send_instr(OP_JAL, 4'd0, 4'd0, 4'd0, 4'd0, 12'h010);
    send_instr(OP_JR, 4'd3, 4'd0, 4'd0, 4'd0, 12'h000);
  endtask

  task automatic test_random_phases();
    int idle_set [4][2] = '{'{0, 0}, '{65, 0}, '{0, 65}, '{18, 18}};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_set[p][0];
      recv_stall_pct = idle_set[p][1];
      send_random(125);
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    hold_off_cycles = 60;
    send_random(20);
    wait_drained();
  endtask

  task automatic test_halt();
    send_instr(OP_HALT, 4'd0, 4'd0, 4'd0, 4'd0, 12'd0);
    recv_stall_pct = 18;
    send_idle_pct = 18;
    send_random(12);
    recv_stall_pct = 0;
    send_idle_pct = 0;
  endtask

  initial begin
    failed = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    foreach (regs_m[i]) regs_m[i] = '0;
    foreach (dmem_m[i]) dmem_m[i] = '0;
    foreach (io_m[i]) io_m[i] = '0;
    pc_m = '0;
    halt_m = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = '0;
    in_ch.dest_reg = '0;
    in_ch.src_a_reg = '0;
    in_ch.src_b_reg = '0;
    in_ch.src_c_reg = '0;
    in_ch.immediate = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_ops();
    test_random_phases();
    test_backpressure();
    test_halt();
    wait_drained();
    repeat (40) @(posedge clk);
    if (!failed && expected_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
